// ===== src/u2k_pkg.sv =====
// ----------------------------------------------------------------------------
// u2k_pkg
// Types, constants and the code point to KOI-7 N2 map for the line converter.
// ----------------------------------------------------------------------------
package u2k_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = PTR_W + 1;

	localparam logic [6:0] LINE_LIMIT_RESET = 7'd80;
	localparam logic [6:0] KOI7_SPACE       = 7'h20;

	// continuation bytes still expected
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	typedef struct packed {
		logic        eol;
		logic [15:0] code;
	} u2k_item_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} u2k_fifo_status_t;

	// KOI-7 codes for the upper case Cyrillic block; lower case reuses them
	localparam logic [6:0] CYR_MAP [32] = '{
		7'h41, 7'h62, 7'h42, 7'h67, 7'h64, 7'h45, 7'h76, 7'h7a,
		7'h69, 7'h6a, 7'h4b, 7'h6c, 7'h4d, 7'h48, 7'h4f, 7'h70,
		7'h50, 7'h43, 7'h54, 7'h59, 7'h66, 7'h58, 7'h63, 7'h7e,
		7'h7b, 7'h7d, 7'h78, 7'h79, 7'h78, 7'h7c, 7'h60, 7'h71
	};

	function automatic logic [6:0] map_code(input logic [15:0] u);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [6:0] r;
		logic [7:0] idx;
		hi  = u[15:8];
		lo  = u[7:0];
		r   = 7'h00;
		idx = lo - 8'h10;
		case (hi)
			8'h00: begin
				if (lo < 8'h60)
					r = lo[6:0];
				else if (lo inside {[8'h61:8'h7a]})
					r = 7'(lo - 8'h20);
			end
			8'h04: begin
				if (lo inside {8'h01, 8'h51})
					r = 7'h45;
				else if (lo inside {[8'h10:8'h4f]})
					r = CYR_MAP[idx[4:0]];
			end
			8'h20: begin
				if (lo == 8'h15)
					r = 7'h2d;
				else if (lo inside {8'h19, 8'h32})
					r = 7'h27;
				else if (lo == 8'h28)
					r = 7'h0a;
			end
			8'h21: begin
				if (lo == 8'h2f)
					r = 7'h45;
				else if (lo == 8'h91)
					r = 7'h40;
			end
			8'h22: begin
				if (lo == 8'h27)
					r = 7'h5e;
				else if (lo == 8'h28)
					r = 7'h76;
				else if (lo == 8'h60)
					r = 7'h23;
			end
			8'h25: begin
				if (lo == 8'hca)
					r = 7'h24;
			end
			default: r = 7'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== src/u2k_ifs.sv =====
// ----------------------------------------------------------------------------
// u2k channel interfaces
// Valid/ready channels for the UTF-8 byte input and the KOI-7 result output.
// ----------------------------------------------------------------------------
interface u2k_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface u2k_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] koi7_char;
	logic       end_of_line;

	modport source (output valid, output koi7_char, output end_of_line, input ready);
	modport sink   (input valid, input koi7_char, input end_of_line, output ready);
endinterface

// ===== src/u2k_front.sv =====
// ----------------------------------------------------------------------------
// u2k_front
// Accepts UTF-8 bytes and assembles code points; pushes code points and
// end-of-line markers into the queue.
// ----------------------------------------------------------------------------
module u2k_front (
	input  logic                      clk,
	input  logic                      arst_n,
	u2k_byte_if.sink                  bytes,
	input  u2k_pkg::u2k_fifo_status_t fifo_status,
	output logic                      push,
	output u2k_pkg::u2k_item_t        push_item
);
	import u2k_pkg::*;

	logic [1:0]  pending_q;
	logic [15:0] partial_q;
	logic [1:0]  pending_d;
	logic [15:0] partial_d;
	logic        accept;
	logic [7:0]  b;

	assign bytes.ready = !fifo_status.full;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.data_byte;

	always_comb begin
		pending_d     = pending_q;
		partial_d     = partial_q;
		push          = 1'b0;
		push_item.eol  = 1'b0;
		push_item.code = 16'h0000;
		if (accept) begin
			if (b == 8'h00) begin
				// a zero byte ends the line even inside a sequence
				push          = 1'b1;
				push_item.eol = 1'b1;
				pending_d     = PEND_NONE;
				partial_d     = 16'h0000;
			end else if (pending_q == PEND_NONE) begin
				if (!b[7]) begin
					push           = 1'b1;
					push_item.code = {8'h00, b};
				end else if (!b[5]) begin
					partial_d = {5'b0, b[4:0], 6'b0};
					pending_d = PEND_ONE;
				end else begin
					partial_d = {b[3:0], 12'b0};
					pending_d = PEND_TWO;
				end
			end else if (pending_q == PEND_TWO) begin
				partial_d = partial_q | {4'b0, b[5:0], 6'b0};
				pending_d = PEND_ONE;
			end else begin
				push           = 1'b1;
				push_item.code = partial_q | {10'b0, b[5:0]};
				partial_d      = 16'h0000;
				pending_d      = PEND_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PEND_NONE;
			partial_q <= 16'h0000;
		end else begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("front: bad pending count");

endmodule

// ===== src/u2k_fifo.sv =====
// ----------------------------------------------------------------------------
// u2k_fifo
// Short queue of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module u2k_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  u2k_pkg::u2k_item_t        push_item,
	input  logic                      pop,
	output u2k_pkg::u2k_item_t        head_item,
	output u2k_pkg::u2k_fifo_status_t status
);
	import u2k_pkg::*;

	u2k_item_t        slots_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign status.not_empty = (count_q != '0);
	assign head_item        = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push)
		else $error("fifo: push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!status.not_empty |-> !pop)
		else $error("fifo: pop while empty");

	a_count_move: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo: count did not follow push");

endmodule

// ===== src/u2k_back.sv =====
// ----------------------------------------------------------------------------
// u2k_back
// Maps queued code points to KOI-7 N2, applies the per-line limit and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module u2k_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [6:0]                line_limit,
	input  u2k_pkg::u2k_fifo_status_t fifo_status,
	input  u2k_pkg::u2k_item_t        head_item,
	output logic                      pop,
	u2k_char_if.source                chars
);
	import u2k_pkg::*;

	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       out_eol_q;
	logic [6:0] emitted_q;
	logic [6:0] mapped;
	logic       emit;

	assign pop    = fifo_status.not_empty && (!out_valid_q || chars.ready);
	assign mapped = map_code(head_item.code);
	// codes below space are dropped, as is everything past the line limit
	assign emit   = (mapped >= KOI7_SPACE) && (emitted_q < line_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			emitted_q   <= 7'd0;
		end else if (pop) begin
			if (head_item.eol) begin
				out_valid_q <= 1'b1;
				emitted_q   <= 7'd0;
			end else if (emit) begin
				out_valid_q <= 1'b1;
				emitted_q   <= emitted_q + 7'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_eol_q  <= head_item.eol;
			out_char_q <= head_item.eol ? 7'd0 : mapped;
		end
	end

	assign chars.valid       = out_valid_q;
	assign chars.koi7_char   = out_char_q;
	assign chars.end_of_line = out_eol_q;

	a_eol_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_eol_q) |-> (out_char_q == 7'd0))
		else $error("back: end marker with nonzero char");

	a_eol_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.eol) |=> (emitted_q == 7'd0))
		else $error("back: count not cleared at end of line");

endmodule

// ===== src/utf8_to_koi7_line_converter.sv =====
// ----------------------------------------------------------------------------
// utf8_to_koi7_line_converter
// UTF-8 byte stream to KOI-7 N2 characters, at most line_limit per line.
//
//   channel     dir  payload                         beat
//   bytes       in   data_byte[7:0]                  one UTF-8 byte
//   chars       out  koi7_char[6:0], end_of_line     one character or marker
//   cfg         in   cfg_wdata[6:0] on cfg_we        line_limit write
//
// One byte per cycle sustained while chars.ready stays high; the byte that
// completes a result is written into the queue, and a later pop maps it into
// the output register, from which it is offered.
// The four-entry queue and the output register decouple the two sides.
// Reset clears decode state, queue and line count, and sets line_limit to 80.
// bytes.ready drops only while the queue holds four items.
// ----------------------------------------------------------------------------
module utf8_to_koi7_line_converter (
	input  logic        clk,
	input  logic        arst_n,
	u2k_byte_if.sink    bytes,
	u2k_char_if.source  chars,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	import u2k_pkg::*;

	logic             line_limit_q;
	logic [6:0]       limit_q;
	logic             push;
	logic             pop;
	u2k_item_t        push_item;
	u2k_item_t        head_item;
	u2k_fifo_status_t fifo_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LINE_LIMIT_RESET;
		else if (cfg_we)
			limit_q <= cfg_wdata;
	end

	// write seen flag kept for the limit register's written state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			line_limit_q <= 1'b0;
		else if (cfg_we)
			line_limit_q <= 1'b1;
	end

	u2k_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.bytes       (bytes),
		.fifo_status (fifo_status),
		.push        (push),
		.push_item   (push_item)
	);

	u2k_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (fifo_status)
	);

	u2k_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_limit  (limit_q),
		.fifo_status (fifo_status),
		.head_item   (head_item),
		.pop         (pop),
		.chars       (chars)
	);

	a_cfg_default: assert property (@(posedge clk) disable iff (!arst_n)
		!line_limit_q |-> (limit_q == LINE_LIMIT_RESET))
		else $error("top: line limit changed without a write");

endmodule
